// ----- rtl/cpf_pkg.sv -----
// ----------------------------------------------------------------------------
// cpf_pkg: shared definitions for the constant pool find-or-add unit
// Holds the result status codes, register indexes, state encoding, the token
// that walks the cell chain and the key comparison used by every cell.
// ----------------------------------------------------------------------------
package cpf_pkg;

  localparam int DEPTH_DEFAULT = 256;
  localparam int KEY_W         = 64;
  localparam int CAP_W         = 9;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 9;
  localparam int OUT_IDX_W     = 8;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 9'd256;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MODE = 1'd1;

  typedef enum logic [1:0] {
    ST_FOUND = 2'd0,
    ST_ADDED = 2'd1,
    ST_FULL  = 2'd2,
    ST_ZERO  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_t;

  typedef struct packed {
    logic active;
    logic found;
  } token_t;

  function automatic logic is_nan(input logic [KEY_W-1:0] b);
    return (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
  endfunction

  function automatic logic keys_equal(input logic [KEY_W-1:0] a,
                                      input logic [KEY_W-1:0] b,
                                      input logic             dbl_mode);
    logic [KEY_W-1:0] both;
    both = a | b;
    if (!dbl_mode) begin
      return a == b;
    end
    if (is_nan(a) || is_nan(b)) begin
      return 1'b0;
    end
    if (both[62:0] == 63'd0) begin
      return 1'b1;
    end
    return a == b;
  endfunction

endpackage

// ----- rtl/cpf_if.sv -----
// ----------------------------------------------------------------------------
// cpf_if: item channels of the constant pool find-or-add unit
// Valid/ready channels for the key items and for the result items.
// ----------------------------------------------------------------------------
interface cpf_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] key;

  modport source (output valid, output key, input ready);
  modport sink (input valid, input key, output ready);
endinterface

interface cpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] entry_index;
  logic [1:0] status;

  modport source (output valid, output entry_index, output status, input ready);
  modport sink (input valid, input entry_index, input status, output ready);
endinterface

// ----- rtl/constant_pool_find_or_add_unit.sv -----
// ----------------------------------------------------------------------------
// constant_pool_find_or_add_unit: deduplicating find-or-add key table
// One key is taken at a time. A scan token walks a chain of DEPTH cells, one
// cell per cycle, and the result is decided when it leaves the last cell; a
// zero key in handle mode is answered without a scan. The next key is taken
// only once the previous result has moved into the output register. The cell
// at the fill count stores the key as the token passes when no lower entry
// matched and room remains. A finished result waits in an output register
// while the next key is taken.
// ----------------------------------------------------------------------------
module constant_pool_find_or_add_unit import cpf_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  cpf_in_if.sink                in_if,
  cpf_out_if.source             out_if
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [CAP_W-1:0]     capacity_r;
  logic                 key_mode_r;
  state_t               state_r, state_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic                 start_r, start_nxt;
  logic [CW-1:0]        fill_r, fill_nxt;
  status_t              res_st_r, res_st_nxt;
  logic [OUT_IDX_W-1:0] res_idx_r, res_idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_st_r, out_st_nxt;
  logic [OUT_IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic                 add_en;
  logic [LW-1:0]        fill_w;
  logic [LW-1:0]        cap_w;
  logic [IW+7:0]        end_idx_ext;
  logic [CW+7:0]        fill_ext;

  token_t        tok  [0:DEPTH];
  logic [IW-1:0] idxc [0:DEPTH];

  assign fill_w      = LW'(fill_r);
  assign cap_w       = LW'(capacity_r);
  assign add_en      = (fill_w < cap_w) && (fill_r < DEPTH_C);
  assign end_idx_ext = {8'd0, idxc[DEPTH]};
  assign fill_ext    = {8'd0, fill_r};

  assign tok[0].active = start_r;
  assign tok[0].found  = 1'b0;
  assign idxc[0]       = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    cpf_cell #(
      .IDX (g),
      .CW  (CW),
      .IW  (IW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .key      (key_r),
      .key_mode (key_mode_r),
      .fill     (fill_r),
      .add_en   (add_en),
      .tok_i    (tok[g]),
      .idx_i    (idxc[g]),
      .tok_o    (tok[g+1]),
      .idx_o    (idxc[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RESET;
      key_mode_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAPACITY: capacity_r <= cfg_data[CAP_W-1:0];
        REG_KEY_MODE: key_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    start_nxt     = 1'b0;
    fill_nxt      = fill_r;
    res_st_nxt    = res_st_r;
    res_idx_nxt   = res_idx_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_st_nxt    = out_st_r;
    out_idx_nxt   = out_idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          key_nxt = in_if.key;
          if (!key_mode_r && (in_if.key == '0)) begin
            res_st_nxt  = ST_ZERO;
            res_idx_nxt = '0;
            state_nxt   = S_RESP;
          end else begin
            start_nxt = 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (tok[DEPTH].active) begin
          if (tok[DEPTH].found) begin
            res_st_nxt  = ST_FOUND;
            res_idx_nxt = end_idx_ext[7:0];
          end else if (add_en) begin
            res_st_nxt  = ST_ADDED;
            res_idx_nxt = fill_ext[7:0];
            fill_nxt    = fill_r + 1'b1;
          end else begin
            res_st_nxt  = ST_FULL;
            res_idx_nxt = '0;
          end
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_idx_nxt   = res_idx_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    res_st_r  <= res_st_nxt;
    res_idx_r <= res_idx_nxt;
    out_st_r  <= out_st_nxt;
    out_idx_r <= out_idx_nxt;
  end

  assign in_if.ready        = (state_r == S_IDLE);
  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_st_r;
  assign out_if.entry_index = out_idx_r;

  a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok[DEPTH].active |-> (state_r == S_SCAN))
    else $error("scan token left the chain outside a scan");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= DEPTH_C)
    else $error("fill count above table depth");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (fill_r != $past(fill_r))) |->
      ((fill_r == CW'($past(fill_r) + 1'b1)) && ($past(state_r) == S_SCAN)))
    else $error("fill count moved by other than one append");

  a_start_once: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |=> !start_r)
    else $error("two scan tokens launched back to back");

endmodule

// ----- rtl/cpf_cell.sv -----
// ----------------------------------------------------------------------------
// cpf_cell: one table entry of the constant pool chain
// Stores one key, compares it with the broadcast key when the scan token
// passes, takes the new key when it is the append slot, and hands the token
// to the next cell in the following cycle.
// ----------------------------------------------------------------------------
module cpf_cell import cpf_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 9,
  parameter int IW  = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [KEY_W-1:0] key,
  input  logic             key_mode,
  input  logic [CW-1:0]    fill,
  input  logic             add_en,
  input  token_t           tok_i,
  input  logic [IW-1:0]    idx_i,
  output token_t           tok_o,
  output logic [IW-1:0]    idx_o
);

  localparam logic [CW-1:0] IDX_C  = CW'(IDX);
  localparam logic [IW-1:0] IDX_IW = IW'(IDX);

  logic [KEY_W-1:0] entry_r;
  logic             hit;
  logic             append;
  token_t           tok_r;
  token_t           tok_nxt;
  logic [IW-1:0]    idx_r;
  logic [IW-1:0]    idx_nxt;

  assign hit    = tok_i.active && !tok_i.found && (IDX_C < fill) &&
                  keys_equal(entry_r, key, key_mode);
  assign append = tok_i.active && !tok_i.found && (IDX_C == fill) && add_en;

  always_comb begin
    tok_nxt.active = tok_i.active;
    tok_nxt.found  = tok_i.found | hit;
    idx_nxt        = hit ? IDX_IW : idx_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (append) begin
      entry_r <= key;
    end
  end

  assign tok_o = tok_r;
  assign idx_o = idx_r;

endmodule

// ----- tb/constant_pool_find_or_add_unit_test.sv -----
// ----------------------------------------------------------------------------
// constant_pool_find_or_add_unit_test: self-checking bench for the key table
// A short table of hand-picked keys goes first: the zero key, the sign bit,
// the all-ones pattern, NaNs, infinities, a full table and a capacity above
// the table depth. Then nine random phases follow, each with its own capacity
// and key mode. A local table model predicts each result no script row fixes.
// Both channels stall at random but in one phase, and once the result side
// holds off long enough to back up the key channel.
// ----------------------------------------------------------------------------
module constant_pool_find_or_add_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cpf_pkg::*;

  localparam int TABLE_DEPTH = DEPTH_DEFAULT;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 100;
  localparam int SCRIPT_ROWS = 22;

  localparam logic [63:0] NEG_ZERO = 64'h8000_0000_0000_0000;
  localparam logic [63:0] POS_INF  = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] NEG_INF  = 64'hFFF0_0000_0000_0000;
  localparam logic [63:0] QNAN     = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] SNAN     = 64'h7FF0_0000_0000_0001;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [7:0] idx;
    status_t    st;
  } answer_t;

  typedef struct packed {
    bit      fixed;
    answer_t ans;
  } tag_t;

  typedef struct packed {
    bit          set_cfg;
    logic [8:0]  cap;
    logic        dbl;
    logic [63:0] key;
    bit          fixed;
    logic [7:0]  idx;
    status_t     st;
  } row_t;

  row_t script [0:SCRIPT_ROWS-1] = '{
    '{1'b0, 9'd0,   1'b0, 64'd0,                  1'b1, 8'd0, ST_ZERO},
    '{1'b0, 9'd0,   1'b0, ALL_ONES,               1'b1, 8'd0, ST_ADDED},
    '{1'b0, 9'd0,   1'b0, 64'd1,                  1'b1, 8'd1, ST_ADDED},
    '{1'b0, 9'd0,   1'b0, ALL_ONES,               1'b1, 8'd0, ST_FOUND},
    '{1'b0, 9'd0,   1'b0, NEG_ZERO,               1'b1, 8'd2, ST_ADDED},
    '{1'b0, 9'd0,   1'b0, 64'd1,                  1'b1, 8'd1, ST_FOUND},
    '{1'b1, 9'd3,   1'b0, 64'd5,                  1'b1, 8'd0, ST_FULL},
    '{1'b0, 9'd0,   1'b0, NEG_ZERO,               1'b0, 8'd0, ST_FOUND},
    '{1'b1, 9'd0,   1'b1, 64'd0,                  1'b0, 8'd0, ST_FOUND},
    '{1'b0, 9'd0,   1'b0, QNAN,                   1'b1, 8'd0, ST_FULL},
    '{1'b0, 9'd0,   1'b0, 64'd1,                  1'b0, 8'd0, ST_FOUND},
    '{1'b0, 9'd0,   1'b0, ALL_ONES,               1'b1, 8'd0, ST_FULL},
    '{1'b1, 9'd511, 1'b1, SNAN,                   1'b0, 8'd0, ST_FOUND},
    '{1'b0, 9'd0,   1'b0, SNAN,                   1'b0, 8'd0, ST_FOUND},
    '{1'b0, 9'd0,   1'b0, POS_INF,                1'b0, 8'd0, ST_FOUND},
    '{1'b0, 9'd0,   1'b0, NEG_INF,                1'b0, 8'd0, ST_FOUND},
    '{1'b0, 9'd0,   1'b0, POS_INF,                1'b0, 8'd0, ST_FOUND},
    '{1'b0, 9'd0,   1'b0, 64'd0,                  1'b0, 8'd0, ST_FOUND},
    '{1'b1, 9'd511, 1'b0, 64'd0,                  1'b1, 8'd0, ST_ZERO},
    '{1'b0, 9'd0,   1'b0, NEG_ZERO,               1'b0, 8'd0, ST_FOUND},
    '{1'b0, 9'd0,   1'b0, ALL_ONES,               1'b0, 8'd0, ST_FOUND},
    '{1'b0, 9'd0,   1'b0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 8'd0, ST_FOUND}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  bit                    idle_en = 1'b1;
  bit                    squeeze = 1'b0;
  int                    n_offered = 0;
  int                    n_done = 0;
  int                    errors = 0;

  logic [63:0] pool_keys [TABLE_DEPTH];
  int          pool_fill = 0;
  logic [8:0]  pool_cap = CAPACITY_RESET;
  logic        pool_dbl = 1'b0;

  tag_t        typed_q [$];
  answer_t     answers [$];
  logic [63:0] seen_keys [$];

  cpf_in_if  key_ch ();
  cpf_out_if res_ch ();

  constant_pool_find_or_add_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_if     (key_ch),
    .out_if    (res_ch)
  );

  always #6 clk = ~clk;

  function automatic bit same_key(input logic [63:0] a, input logic [63:0] b);
    bit a_nan;
    bit b_nan;
    if (!pool_dbl) begin
      return a == b;
    end
    a_nan = (&a[62:52]) && (|a[51:0]);
    b_nan = (&b[62:52]) && (|b[51:0]);
    if (a_nan || b_nan) begin
      return 1'b0;
    end
    if (a[62:0] == 63'd0 && b[62:0] == 63'd0) begin
      return 1'b1;
    end
    return a == b;
  endfunction

  function automatic answer_t look_up(input logic [63:0] k);
    answer_t a;
    int      lim;
    int      i;
    a.idx = 8'd0;
    a.st  = ST_FULL;
    lim = (pool_cap < TABLE_DEPTH) ? int'(pool_cap) : TABLE_DEPTH;
    if (!pool_dbl && k == 64'd0) begin
      a.st = ST_ZERO;
      return a;
    end
    for (i = 0; i < pool_fill; i++) begin
      if (same_key(pool_keys[i], k)) begin
        a.idx = 8'(i);
        a.st  = ST_FOUND;
        return a;
      end
    end
    if (pool_fill < lim) begin
      pool_keys[pool_fill] = k;
      a.idx = 8'(pool_fill);
      a.st  = ST_ADDED;
      pool_fill++;
    end
    return a;
  endfunction

  function automatic logic [63:0] pick_key();
    logic [63:0] k;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 45 && seen_keys.size() > 0) begin
      k = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
    end else if (r < 58) begin
      case ($urandom_range(0, 5))
        0: k = 64'd0;
        1: k = NEG_ZERO;
        2: k = POS_INF;
        3: k = NEG_INF;
        4: k = QNAN;
        default: k = ALL_ONES;
      endcase
      if (k[62:0] == 63'd0 && $urandom_range(0, 1) == 1) begin
        k[63] = ~k[63];
      end
    end else if (r < 66) begin
      k = {1'($urandom), 11'h7FF, 20'($urandom), $urandom | 32'd1};
    end else begin
      k = {$urandom, $urandom};
      seen_keys.push_back(k);
    end
    return k;
  endfunction

  task automatic send_key(input logic [63:0] k, input bit fixed,
                          input logic [7:0] idx, input status_t st);
    tag_t t;
    while (idle_en && $urandom_range(0, 99) < 25) begin
      key_ch.valid <= 1'b0;
      @(posedge clk);
    end
    t.fixed   = fixed;
    t.ans.idx = idx;
    t.ans.st  = st;
    typed_q.push_back(t);
    key_ch.valid <= 1'b1;
    key_ch.key   <= k;
    @(posedge clk);
    while (!key_ch.ready) @(posedge clk);
    n_offered++;
  endtask

  task automatic settle();
    key_ch.valid <= 1'b0;
    @(posedge clk);
    while (n_done != n_offered) @(posedge clk);
  endtask

  task automatic set_table(input logic [8:0] cap, input logic dbl);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_CAPACITY;
    cfg_data  <= cap;
    @(posedge clk);
    cfg_index <= REG_KEY_MODE;
    cfg_data  <= {8'd0, dbl};
    @(posedge clk);
    cfg_we   <= 1'b0;
    pool_cap = cap;
    pool_dbl = dbl;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= !squeeze && !(idle_en && $urandom_range(0, 99) < 25);
    end
  end

  always @(posedge clk) begin : watch
    tag_t    t;
    answer_t want;
    if (rst_n) begin
      if (key_ch.valid && key_ch.ready) begin
        t = typed_q.pop_front();
        want = look_up(key_ch.key);
        if (t.fixed) begin
          want = t.ans;
        end
        answers.push_back(want);
      end
      if (res_ch.valid && res_ch.ready) begin
        if (answers.size() == 0) begin
          $error("result item with nothing expected: entry_index %0d, status %0d",
                 res_ch.entry_index, res_ch.status);
          errors++;
        end else begin
          want = answers.pop_front();
          n_done++;
          if (res_ch.entry_index !== want.idx) begin
            $error("entry_index: expected %0d, got %0d", want.idx, res_ch.entry_index);
            errors++;
          end
          if (res_ch.status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, res_ch.status);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    wait (n_offered >= 300);
    @(posedge clk);
    squeeze <= 1'b1;
    repeat (2000) @(posedge clk);
    squeeze <= 1'b0;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [8:0] cap;
    logic       dbl;
    key_ch.valid = 1'b0;
    key_ch.key   = 64'd0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      if (script[i].set_cfg) begin
        set_table(script[i].cap, script[i].dbl);
      end
      send_key(script[i].key, script[i].fixed, script[i].idx, script[i].st);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: cap = 9'd511;
        2: cap = 9'd0;
        3: cap = 9'd256;
        PHASES - 1: cap = 9'd256;
        default: begin
          if ($urandom_range(0, 1) == 1) begin
            cap = 9'($urandom_range(pool_fill, 511));
          end else begin
            cap = 9'($urandom_range(0, 511));
          end
        end
      endcase
      dbl = (ph == 0) ? 1'b1 : (ph == 1) ? 1'b0 : 1'($urandom_range(0, 1));
      set_table(cap, dbl);
      idle_en <= (ph != 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_key(pick_key(), 1'b0, 8'd0, ST_FOUND);
      end
    end

    settle();
    repeat (TABLE_DEPTH + 20) @(posedge clk);
    if (answers.size() != 0) begin
      $error("%0d expected results never arrived", answers.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/cpf_pkg.sv
rtl/cpf_if.sv
rtl/cpf_cell.sv
rtl/constant_pool_find_or_add_unit.sv
tb/constant_pool_find_or_add_unit_test.sv
